[rtl/ukev_pkg.sv]
`default_nettype none

package ukev_pkg;

	// Report geometry
	localparam int KEY_SLOTS   = 6;
	localparam int INPUT_SLOTS = 6;
	localparam int LIVE_SLOTS  = (KEY_SLOTS < INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;
	localparam int MOD_BITS    = 8;
	localparam int MOD_IW      = 3;

	// Scan: one candidate event per step (modifiers, presses, releases)
	localparam int SCAN_LEN = MOD_BITS + 2 * LIVE_SLOTS;
	localparam int IDX_W    = $clog2(SCAN_LEN);
	localparam int SLOT_IW  = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;

	localparam logic [7:0] ROLLOVER_CODE = 8'h01;
	localparam logic [7:0] EMPTY_USAGE   = 8'h00;

	typedef logic [LIVE_SLOTS-1:0][7:0]  slots_t;
	typedef logic [INPUT_SLOTS-1:0][7:0] in_slots_t;

	typedef struct packed {
		logic [7:0] mods;
		in_slots_t  slots;
	} report_t;

	typedef struct packed {
		logic       ordinary;
		logic [7:0] code;
		logic       down;
	} event_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rollover;
		logic hit;
		logic last_step;
		logic hold_valid;
		logic out_free;
	} dp_sts_t;

	// Usages with a key mapping
	function automatic logic usage_mapable(input logic [7:0] u);
		return ((u >= 8'h04) && (u <= 8'h31)) ||
		       ((u >= 8'h33) && (u <= 8'h47)) ||
		       ((u >= 8'h49) && (u <= 8'h63)) ||
		       (u == 8'h65);
	endfunction

	// Membership over all live slots, empty ones included
	function automatic logic slots_hold(input slots_t s, input logic [7:0] u);
		logic found;
		found = 1'b0;
		for (int i = 0; i < LIVE_SLOTS; i++) begin
			if (s[i] == u)
				found = 1'b1;
		end
		return found;
	endfunction

endpackage

`default_nettype wire

[rtl/ukev_ifs.sv]
`default_nettype none

// Report request channel
interface ukev_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifier_bits;
	logic [7:0] slot_0;
	logic [7:0] slot_1;
	logic [7:0] slot_2;
	logic [7:0] slot_3;
	logic [7:0] slot_4;
	logic [7:0] slot_5;

	modport source (output valid, modifier_bits, slot_0, slot_1, slot_2, slot_3, slot_4,
		slot_5, input ready);
	modport sink (input valid, modifier_bits, slot_0, slot_1, slot_2, slot_3, slot_4,
		slot_5, output ready);
endinterface

// Key event request channel
interface ukev_event_if;
	logic       valid;
	logic       ready;
	logic       is_ordinary_key;
	logic [7:0] event_code;
	logic       went_down;
	logic       final_event;

	modport source (output valid, is_ordinary_key, event_code, went_down, final_event,
		input ready);
	modport sink (input valid, is_ordinary_key, event_code, went_down, final_event,
		output ready);
endinterface

`default_nettype wire

[rtl/ukev_dpath.sv]
`default_nettype none

module ukev_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  ukev_pkg::report_t report,
	input  ukev_pkg::dp_cmd_t cmd,
	output ukev_pkg::dp_sts_t sts,
	input  logic              out_ready,
	output ukev_pkg::event_t  out_event,
	output logic              out_final,
	output logic              out_valid
);
	import ukev_pkg::*;

	logic [7:0]       mods_new_q, mods_old_q;
	slots_t           slots_new_q, slots_old_q;
	logic [IDX_W-1:0] idx_q;
	logic             pstop_q, rstop_q;
	event_t           hold_q;
	logic             hold_valid_q;
	event_t           out_q;
	logic             out_final_q, out_valid_q;

	logic [IDX_W-1:0]  p_off, r_off;
	logic [SLOT_IW-1:0] p_sel, r_sel;
	logic [7:0]         p_use, r_use;
	logic [MOD_IW-1:0]  m_sel;
	logic               in_mod, in_press, p_zero, r_zero;
	logic               hit, rollover;
	event_t             cur;
	logic               push_mid, push_end;

	// Phase decode and slot selection
	assign in_mod   = (idx_q < IDX_W'(MOD_BITS));
	assign in_press = !in_mod && (idx_q < IDX_W'(MOD_BITS + LIVE_SLOTS));
	assign p_off    = idx_q - IDX_W'(MOD_BITS);
	assign r_off    = idx_q - IDX_W'(MOD_BITS + LIVE_SLOTS);
	assign p_sel    = p_off[SLOT_IW-1:0];
	assign r_sel    = r_off[SLOT_IW-1:0];
	assign m_sel    = idx_q[MOD_IW-1:0];
	assign p_use    = slots_new_q[p_sel];
	assign r_use    = slots_old_q[r_sel];
	assign p_zero   = (p_use == EMPTY_USAGE);
	assign r_zero   = (r_use == EMPTY_USAGE);

	// Candidate event at the current step
	always_comb begin
		cur = '0;
		hit = 1'b0;
		if (in_mod) begin
			cur.ordinary = 1'b0;
			cur.code     = 8'(m_sel);
			cur.down     = mods_new_q[m_sel];
			hit          = mods_new_q[m_sel] ^ mods_old_q[m_sel];
		end else if (in_press) begin
			cur.ordinary = 1'b1;
			cur.code     = p_use;
			cur.down     = 1'b1;
			hit          = !pstop_q && !p_zero && usage_mapable(p_use) &&
			               !slots_hold(slots_old_q, p_use);
		end else begin
			cur.ordinary = 1'b1;
			cur.code     = r_use;
			cur.down     = 1'b0;
			hit          = !rstop_q && !r_zero && usage_mapable(r_use) &&
			               !slots_hold(slots_new_q, r_use);
		end
	end

	// Rollover error: every live slot holds the error usage
	always_comb begin
		rollover = 1'b1;
		for (int i = 0; i < LIVE_SLOTS; i++) begin
			if (report.slots[i] != ROLLOVER_CODE)
				rollover = 1'b0;
		end
	end

	assign push_mid = cmd.step && hit && hold_valid_q;
	assign push_end = cmd.flush && hold_valid_q;

	// Report registers and kept report
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mods_new_q <= report.mods;
			for (int i = 0; i < LIVE_SLOTS; i++)
				slots_new_q[i] <= report.slots[i];
		end
		if (cmd.step && hit)
			hold_q <= cur;
		if (push_mid || push_end) begin
			out_q       <= hold_q;
			out_final_q <= push_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_old_q  <= '0;
			slots_old_q <= '0;
		end else if (cmd.flush) begin
			mods_old_q  <= mods_new_q;
			slots_old_q <= slots_new_q;
		end
	end

	// Scan counter and empty-slot stops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pstop_q <= 1'b0;
			rstop_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q   <= '0;
			pstop_q <= 1'b0;
			rstop_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (in_press && p_zero)
				pstop_q <= 1'b1;
			if (!in_mod && !in_press && r_zero)
				rstop_q <= 1'b1;
		end
	end

	// One-event hold, so the last event can be marked final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_valid_q <= 1'b0;
		else if (cmd.flush)
			hold_valid_q <= 1'b0;
		else if (cmd.step && hit)
			hold_valid_q <= 1'b1;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push_mid || push_end)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign sts.rollover   = rollover;
	assign sts.hit        = hit;
	assign sts.last_step  = (idx_q == IDX_W'(SCAN_LEN - 1));
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_event = out_q;
	assign out_final = out_final_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/ukev_ctrl.sv]
`default_nettype none

module ukev_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ukev_pkg::dp_sts_t sts,
	output ukev_pkg::dp_cmd_t cmd
);
	import ukev_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Commands
	assign cmd.load  = in_ready && in_valid && !sts.rollover;
	assign cmd.step  = (state_q == S_SCAN) &&
	                   !(sts.hit && sts.hold_valid && !sts.out_free);
	assign cmd.flush = (state_q == S_DRAIN) && (!sts.hold_valid || sts.out_free);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				if (cmd.step && sts.last_step)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (cmd.flush)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

[rtl/usb_keyboard_report_to_key_events_unit.sv]
// Channel     Dir  Payload                                          Accepted when
// report_in   in   modifier_bits, slot_0 .. slot_5                  valid && ready
// event_out   out  is_ordinary_key, event_code, went_down,          valid && ready
//                  final_event
//
// A report is accepted, then scanned over 20 steps, then drained. The scan counter
// tests one candidate event (modifier bit, new slot or old slot) per cycle while
// the scan is not held. A rollover report is dropped in its accept cycle.
// A stalled event output holds the scan whenever a second event is ready to leave.
// Reset clears the kept report to zero and returns the controller to idle.
`default_nettype none

module usb_keyboard_report_to_key_events_unit (
	input  logic clk,
	input  logic arst_n,
	ukev_report_if.sink  report_in,
	ukev_event_if.source event_out
);
	import ukev_pkg::*;

	report_t report;
	dp_cmd_t cmd;
	dp_sts_t sts;
	event_t  ev;
	logic    ev_final, ev_valid;

	// Gather the request payload
	assign report.mods     = report_in.modifier_bits;
	assign report.slots[0] = report_in.slot_0;
	assign report.slots[1] = report_in.slot_1;
	assign report.slots[2] = report_in.slot_2;
	assign report.slots[3] = report_in.slot_3;
	assign report.slots[4] = report_in.slot_4;
	assign report.slots[5] = report_in.slot_5;

	ukev_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (report_in.valid),
		.in_ready (report_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ukev_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (event_out.ready),
		.out_event (ev),
		.out_final (ev_final),
		.out_valid (ev_valid)
	);

	assign event_out.valid           = ev_valid;
	assign event_out.is_ordinary_key = ev.ordinary;
	assign event_out.event_code      = ev.code;
	assign event_out.went_down       = ev.down;
	assign event_out.final_event     = ev_final;

`ifndef NO_ASSERTIONS
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_in.ready |-> !sts.hold_valid)
		else $error("held event left over while idle");

	a_rollover_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(report_in.valid && report_in.ready && sts.rollover) |=> report_in.ready)
		else $error("rollover report started a scan");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.hit && sts.hold_valid) |-> sts.out_free)
		else $error("event pushed into a busy output register");

	a_flush_final: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && sts.hold_valid) |=> (event_out.valid && event_out.final_event))
		else $error("last event of a report not marked final");
`endif

endmodule

`default_nettype wire

[sim/tb_usb_keyboard_report_to_key_events_unit.sv]
module tb_usb_keyboard_report_to_key_events_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ukev_pkg::*;

	localparam int LIMIT_CYCLES  = 3_000_000;
	localparam int DRAIN_CYCLES  = 30;
	localparam int RANDOM_KEYED  = 222;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_INTERVAL = 130;

	// One key event as it leaves the block
	typedef struct packed {
		event_t ev;
		logic   last;
	} key_event_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	ukev_report_if report_in ();
	ukev_event_if  event_out ();

	usb_keyboard_report_to_key_events_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.report_in (report_in),
		.event_out (event_out)
	);

	// Driven request and ready, known from time zero
	report_t rep_drv   = '0;
	logic    rep_valid = 1'b0;
	logic    ev_ready  = 1'b0;

	assign report_in.valid         = rep_valid;
	assign report_in.modifier_bits = rep_drv.mods;
	assign report_in.slot_0        = rep_drv.slots[0];
	assign report_in.slot_1        = rep_drv.slots[1];
	assign report_in.slot_2        = rep_drv.slots[2];
	assign report_in.slot_3        = rep_drv.slots[3];
	assign report_in.slot_4        = rep_drv.slots[4];
	assign report_in.slot_5        = rep_drv.slots[5];
	assign event_out.ready         = ev_ready;

	report_t    reports_to_send[$];
	key_event_t pending_events[$];

	// Kept report, as the block should hold it
	logic [7:0] kept_mods = '0;
	slots_t     kept_keys = '0;

	int   n_total      = 0;
	int   n_accepted   = 0;
	int   n_errors     = 0;
	int   cycle_count  = 0;
	logic report_taken = 1'b0;
	logic hold_off     = 1'b0;
	int   hold_left    = 0;
	int   next_hold_at = 60;
	int   send_gap     = 0;
	int   stall_left   = 0;

	// Quiet windows with no idling on either side
	wire calm = (cycle_count % 2500) >= 2100;

	function automatic logic is_mapable(logic [7:0] u);
		return u inside {[8'h04:8'h31], [8'h33:8'h47], [8'h49:8'h63], 8'h65};
	endfunction

	function automatic logic held_in(slots_t s, logic [7:0] u);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < LIVE_SLOTS; i++)
			if (s[i] == u)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic key_event_t make_event(logic ordinary, logic [7:0] code, logic down);
		key_event_t e;
		e.ev.ordinary = ordinary;
		e.ev.code     = code;
		e.ev.down     = down;
		e.last        = 1'b0;
		return e;
	endfunction

	// Presses (or releases): slots of one report up to the first empty one,
	// tested against every slot of the other
	function automatic void scan_keys(slots_t from, slots_t against, logic down,
			inout key_event_t evs[$]);
		logic stop;
		stop = 1'b0;
		for (int i = 0; i < LIVE_SLOTS; i++) begin
			if (from[i] == EMPTY_USAGE)
				stop = 1'b1;
			if (!stop && is_mapable(from[i]) && !held_in(against, from[i]))
				evs.push_back(make_event(1'b1, from[i], down));
		end
	endfunction

	// Events expected from one accepted report; updates the kept report
	function automatic void predict_key_events(report_t r);
		key_event_t evs[$];
		slots_t     cur;
		logic       rollover;
		logic [7:0] diff;
		rollover = 1'b1;
		for (int i = 0; i < LIVE_SLOTS; i++) begin
			cur[i] = r.slots[i];
			if (r.slots[i] != ROLLOVER_CODE)
				rollover = 1'b0;
		end
		if (rollover)
			return;
		diff = r.mods ^ kept_mods;
		for (int i = 0; i < MOD_BITS; i++)
			if (diff[i])
				evs.push_back(make_event(1'b0, 8'(i), r.mods[i]));
		scan_keys(cur, kept_keys, 1'b1, evs);
		scan_keys(kept_keys, cur, 1'b0, evs);
		if (evs.size() > 0)
			evs[evs.size()-1].last = 1'b1;
		foreach (evs[i])
			pending_events.push_back(evs[i]);
		kept_mods = r.mods;
		kept_keys = cur;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 55)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic report_t mk_report(logic [7:0] m, logic [7:0] s0, logic [7:0] s1,
			logic [7:0] s2, logic [7:0] s3, logic [7:0] s4, logic [7:0] s5);
		report_t r;
		r.mods     = m;
		r.slots[0] = s0;
		r.slots[1] = s1;
		r.slots[2] = s2;
		r.slots[3] = s3;
		r.slots[4] = s4;
		r.slots[5] = s5;
		return r;
	endfunction

	function automatic logic [7:0] rand_usage();
		logic [7:0] u;
		u = 8'($urandom_range(8'h04, 8'h65));
		while (!is_mapable(u))
			u = 8'($urandom_range(8'h04, 8'h65));
		return u;
	endfunction

	// Next report of a typing session: small changes to the last one,
	// with some noise and rollover errors mixed in
	function automatic report_t next_random_report(report_t prev);
		report_t    r;
		int         pick;
		int         a;
		int         b;
		logic [7:0] t;
		r    = prev;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.mods = 8'($urandom);
			for (int i = 0; i < INPUT_SLOTS; i++)
				r.slots[i] = ROLLOVER_CODE;
		end else if (pick < 20) begin
			r.mods = 8'($urandom);
			for (int i = 0; i < INPUT_SLOTS; i++)
				r.slots[i] = 8'($urandom);
		end else if (pick < 28) begin
			a          = $urandom_range(0, INPUT_SLOTS - 1);
			b          = $urandom_range(0, INPUT_SLOTS - 1);
			t          = r.slots[a];
			r.slots[a] = r.slots[b];
			r.slots[b] = t;
		end else begin
			r.mods = prev.mods ^ (8'($urandom) & 8'($urandom) & 8'($urandom));
			for (int i = 0; i < INPUT_SLOTS; i++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						r.slots[i] = rand_usage();
					end
					2: begin
						r.slots[i] = EMPTY_USAGE;
					end
					3: begin
						r.slots[i] = 8'($urandom);
					end
					default: begin
					end
				endcase
			end
		end
		return r;
	endfunction

	// Stimulus, reset and end of run
	initial begin
		report_t prev;
		report_t r;
		int      keyed;

		// Directed requests
		reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		reports_to_send.push_back(mk_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		reports_to_send.push_back(mk_report(8'hA5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		// rollover error: dropped, kept report unchanged
		reports_to_send.push_back(mk_report(8'h5A, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
		reports_to_send.push_back(mk_report(8'hA5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
		// every modifier flips, six presses, six releases
		reports_to_send.push_back(mk_report(8'h5A, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
		reports_to_send.push_back(mk_report(8'h5A, 8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A));
		// empty slots in the middle: scan stops, membership and storage do not
		reports_to_send.push_back(mk_report(8'h5A, 8'h0A, 8'h00, 8'h0C, 8'h31, 8'h00, 8'h0F));
		reports_to_send.push_back(mk_report(8'h5A, 8'h31, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00));
		// repeated usage
		reports_to_send.push_back(mk_report(8'h00, 8'h10, 8'h10, 8'h10, 8'h00, 8'h00, 8'h00));
		reports_to_send.push_back(mk_report(8'h00, 8'h01, 8'h02, 8'h03, 8'h32, 8'h48, 8'h64));
		reports_to_send.push_back(mk_report(8'h00, 8'h66, 8'hFF, 8'h80, 8'hE0, 8'hE7, 8'h00));
		// edges of the mapable ranges
		reports_to_send.push_back(mk_report(8'hFF, 8'h31, 8'h33, 8'h47, 8'h49, 8'h63, 8'h65));
		reports_to_send.push_back(mk_report(8'hFF, 8'h04, 8'h30, 8'h34, 8'h46, 8'h4A, 8'h62));
		reports_to_send.push_back(mk_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h02));
		reports_to_send.push_back(mk_report(8'h80, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
		reports_to_send.push_back(mk_report(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		reports_to_send.push_back(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

		// Random typing sessions; rollover errors do not count
		prev  = '0;
		keyed = 0;
		while (keyed < RANDOM_KEYED) begin
			r = next_random_report(prev);
			reports_to_send.push_back(r);
			if (r.slots != {INPUT_SLOTS{ROLLOVER_CODE}}) begin
				prev = r;
				keyed++;
			end
		end
		n_total = reports_to_send.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_total)
			@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Report driver: next request from the queue, random gaps between requests
	always @(negedge clk) begin
		if (arst_n) begin
			if (report_taken)
				send_gap = hold_off ? 0 : idle_len();
			if (!rep_valid || report_taken) begin
				if (send_gap > 0 && !hold_off) begin
					rep_valid <= 1'b0;
					send_gap--;
				end else if (reports_to_send.size() > 0) begin
					rep_drv   <= reports_to_send.pop_front();
					rep_valid <= 1'b1;
				end else begin
					rep_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the event side so that the block backs up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0)
					hold_off <= 1'b0;
			end else if (n_accepted >= next_hold_at) begin
				hold_off     <= 1'b1;
				hold_left    = HOLD_CYCLES;
				next_hold_at += HOLD_INTERVAL;
			end
		end
	end

	// Event ready with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off) begin
				ev_ready <= 1'b0;
			end else if (stall_left > 0) begin
				ev_ready <= 1'b0;
				stall_left--;
			end else begin
				ev_ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = idle_len();
			end
		end
	end

	// Monitor: check events leaving, predict from requests taken
	always @(posedge clk) begin
		report_t    taken;
		key_event_t got;
		key_event_t want;
		report_taken = 1'b0;
		if (arst_n) begin
			if (event_out.valid && event_out.ready) begin
				got.ev.ordinary = event_out.is_ordinary_key;
				got.ev.code     = event_out.event_code;
				got.ev.down     = event_out.went_down;
				got.last        = event_out.final_event;
				if (pending_events.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: unexpected event ord=%b code=%h down=%b last=%b",
							$realtime, got.ev.ordinary, got.ev.code, got.ev.down, got.last);
				end else begin
					want = pending_events.pop_front();
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("%0t: mismatch exp %b/%h/%b/%b got %b/%h/%b/%b",
								$realtime, want.ev.ordinary, want.ev.code, want.ev.down,
								want.last, got.ev.ordinary, got.ev.code, got.ev.down,
								got.last);
					end
				end
			end
			if (report_in.valid && report_in.ready) begin
				taken = mk_report(report_in.modifier_bits, report_in.slot_0, report_in.slot_1,
					report_in.slot_2, report_in.slot_3, report_in.slot_4, report_in.slot_5);
				predict_key_events(taken);
				n_accepted++;
				report_taken = 1'b1;
			end
		end
	end

endmodule
